FILE: sv/kvpp_pkg.sv
// kvpp_pkg: shared types and constants of the key/value packet parser
// holds the result kind codes and the run descriptor passed from front to back
// no dependencies
`timescale 1ns / 1ps

package kvpp_pkg;

    // most results one input byte can cause
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    // depth of the queue between parser and result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kind codes
    typedef enum logic [2:0] {
        KIND_KEY   = 3'd0,
        KIND_BYTE  = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_BAD   = 3'd3,
        KIND_END   = 3'd4
    } kvpp_kind_t;

    // one pending result
    typedef struct packed {
        kvpp_kind_t  kind;
        logic [7:0]  value;
    } kvpp_slot_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic signed [31:0]              key;
        kvpp_slot_t [MAX_RESULTS-1:0]    slots;
    } kvpp_run_t;

endpackage

FILE: sv/kvpp_front.sv
// kvpp_front: byte parser, classifies each input byte and builds its result run
// holds the per-packet parse state (phase, marker, key accumulator)
// depends on kvpp_pkg
`timescale 1ns / 1ps

module kvpp_front #(
    parameter int KEY_BUFFER_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_packet,
    output kvpp_pkg::kvpp_run_t run,
    output logic                push
);

    localparam int LEN_W = $clog2(KEY_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(KEY_BUFFER_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_OK  = LEN_W'(KEY_BUFFER_BYTES - 2);

    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_SOH     = 8'h01;
    localparam logic [7:0] BYTE_NINE    = 8'h39;
    localparam logic [7:0] BYTE_MARK_HI = 8'hC0;
    localparam logic [7:0] BYTE_MARK_LO = 8'h80;
    localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_START,
        PH_KEY,
        PH_VALUE,
        PH_SKIPM,
        PH_SKIP2,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        NP_SPACE,
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } num_phase_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [31:0]      acc;
        num_phase_t       np;
        logic             neg;
    } key_st_t;

    phase_t           phase_reg, phase_next;
    logic             pending_reg, pending_next;
    key_st_t          key_reg, key_next;
    logic             nine_reg, nine_next;
    logic             first_reg, first_next;
    logic [1:0]       skip_reg, skip_next;
    logic             soh_reg, soh_next;

    key_st_t          take_in, take_out;
    logic [LEN_W-1:0] len_c0;
    logic [31:0]      key_val;
    logic             nine_v;
    logic             stop;

    // saturating key length count
    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] len);
        return (len == LEN_SAT) ? len : len + LEN_W'(1);
    endfunction

    // append one result to a run
    function automatic kvpp_pkg::kvpp_run_t add_result(
        input kvpp_pkg::kvpp_run_t r,
        input kvpp_pkg::kvpp_kind_t kind,
        input logic [7:0] value
    );
        kvpp_pkg::kvpp_run_t o;
        o = r;
        o.slots[r.count[kvpp_pkg::SLOT_W-1:0]].kind  = kind;
        o.slots[r.count[kvpp_pkg::SLOT_W-1:0]].value = value;
        o.count = r.count + kvpp_pkg::CNT_W'(1);
        return o;
    endfunction

    // one key byte into the strtol-style number reader
    function automatic key_st_t key_take(input key_st_t s, input logic [7:0] b);
        key_st_t     r;
        logic        digit;
        logic        blank;
        logic [35:0] t;
        r     = s;
        digit = (b >= 8'h30) && (b <= 8'h39);
        blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
        t     = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {32'b0, b[3:0]};
        r.len = sat_inc(s.len);
        unique case (s.np)
            NP_SPACE:
            begin
                if (blank)
                begin
                    r.np = NP_SPACE;
                end
                else if (b == 8'h2B)
                begin
                    r.np = NP_SIGN;
                end
                else if (b == 8'h2D)
                begin
                    r.neg = 1'b1;
                    r.np  = NP_SIGN;
                end
                else if (digit)
                begin
                    r.acc = {28'b0, b[3:0]};
                    r.np  = NP_DIGITS;
                end
                else
                begin
                    r.np = NP_DONE;
                end
            end
            NP_SIGN:
            begin
                if (digit)
                begin
                    r.acc = {28'b0, b[3:0]};
                    r.np  = NP_DIGITS;
                end
                else
                begin
                    r.np = NP_DONE;
                end
            end
            NP_DIGITS:
            begin
                if (digit)
                begin
                    r.acc = (t > {4'b0, MAG_CAP}) ? MAG_CAP : t[31:0];
                end
                else
                begin
                    r.np = NP_DONE;
                end
            end
            NP_DONE:
            begin
                r.np = NP_DONE;
            end
            default:
            begin
                r.np = NP_DONE;
            end
        endcase
        return r;
    endfunction

    // number reader input: fresh state at a key start, else the held state
    always_comb
    begin
        if (phase_reg == PH_START)
        begin
            take_in = '{len: '0, acc: '0, np: NP_SPACE, neg: 1'b0};
        end
        else
        begin
            take_in = key_reg;
        end
        take_out = key_take(take_in, data_byte);
        len_c0   = sat_inc(key_reg.len);
    end

    // saturated signed key from the held magnitude
    always_comb
    begin
        if (key_reg.neg)
        begin
            key_val = (key_reg.acc >= MAG_CAP) ? MAG_CAP : (32'd0 - key_reg.acc);
        end
        else
        begin
            key_val = (key_reg.acc >= MAG_CAP) ? POS_MAX : key_reg.acc;
        end
    end

    // next parse state and the result run of this byte
    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        key_next     = key_reg;
        skip_next    = skip_reg;
        soh_next     = soh_reg;
        nine_v       = first_reg ? (data_byte == BYTE_NINE) : nine_reg;
        nine_next    = nine_v;
        first_next   = 1'b0;
        stop         = 1'b0;
        run          = '0;

        unique case (phase_reg)
            PH_START:
            begin
                if (!end_of_packet)
                begin
                    soh_next = 1'b0;
                    if (!(soh_reg && nine_v && (data_byte == BYTE_SOH)))
                    begin
                        pending_next = 1'b0;
                        if (data_byte == BYTE_NUL)
                        begin
                            phase_next = PH_SKIPM;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            key_next   = take_in;
                            if (data_byte == BYTE_MARK_HI)
                            begin
                                pending_next = 1'b1;
                            end
                            else
                            begin
                                key_next = take_out;
                            end
                        end
                    end
                end
            end
            PH_KEY:
            begin
                if (pending_reg && (data_byte == BYTE_MARK_LO))
                begin
                    // key closed by its marker
                    pending_next = 1'b0;
                    if ((key_reg.len >= LEN_W'(1)) && (key_reg.len <= LEN_OK))
                    begin
                        run        = add_result(run, kvpp_pkg::KIND_KEY, 8'h00);
                        run.key    = key_val;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_SKIP2;
                        skip_next  = 2'd2;
                    end
                end
                else if (pending_reg)
                begin
                    // held C0 was an ordinary byte and ends the number
                    key_next.np = NP_DONE;
                    if (data_byte == BYTE_MARK_HI)
                    begin
                        key_next.len = len_c0;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        key_next.len = sat_inc(len_c0);
                        pending_next = 1'b0;
                    end
                end
                else if (data_byte == BYTE_MARK_HI)
                begin
                    pending_next = 1'b1;
                end
                else
                begin
                    key_next = take_out;
                end
            end
            PH_VALUE:
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    if (data_byte == BYTE_MARK_LO)
                    begin
                        run        = add_result(run, kvpp_pkg::KIND_DONE, 8'h00);
                        phase_next = PH_START;
                        soh_next   = 1'b1;
                        stop       = 1'b1;
                    end
                    else
                    begin
                        run = add_result(run, kvpp_pkg::KIND_BYTE, BYTE_MARK_HI);
                    end
                end
                if (!stop)
                begin
                    if (data_byte == BYTE_NUL)
                    begin
                        run        = add_result(run, kvpp_pkg::KIND_BAD, 8'h00);
                        phase_next = PH_IGNORE;
                    end
                    else if (data_byte == BYTE_MARK_HI)
                    begin
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        run = add_result(run, kvpp_pkg::KIND_BYTE, data_byte);
                    end
                end
            end
            PH_SKIPM:
            begin
                if (pending_reg && (data_byte == BYTE_MARK_LO))
                begin
                    pending_next = 1'b0;
                    phase_next   = PH_START;
                    soh_next     = 1'b0;
                end
                else
                begin
                    pending_next = (data_byte == BYTE_MARK_HI);
                end
            end
            PH_SKIP2:
            begin
                if (skip_reg <= 2'd1)
                begin
                    skip_next  = 2'd0;
                    phase_next = PH_START;
                    soh_next   = 1'b1;
                end
                else
                begin
                    skip_next = skip_reg - 2'd1;
                end
            end
            PH_IGNORE:
            begin
                phase_next = PH_IGNORE;
            end
            default:
            begin
                phase_next = PH_IGNORE;
            end
        endcase

        // packet end closes an open value and resets per-packet state
        if (end_of_packet)
        begin
            if (phase_next == PH_VALUE)
            begin
                if (pending_next)
                begin
                    run = add_result(run, kvpp_pkg::KIND_BYTE, BYTE_MARK_HI);
                end
                run = add_result(run, kvpp_pkg::KIND_BAD, 8'h00);
            end
            run          = add_result(run, kvpp_pkg::KIND_END, 8'h00);
            phase_next   = PH_START;
            pending_next = 1'b0;
            key_next     = '{len: '0, acc: '0, np: NP_SPACE, neg: 1'b0};
            nine_next    = 1'b0;
            first_next   = 1'b1;
            skip_next    = 2'd0;
            soh_next     = 1'b0;
        end
    end

    assign push = accept && (run.count != '0);

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pending_reg <= 1'b0;
            key_reg     <= '{len: '0, acc: '0, np: NP_SPACE, neg: 1'b0};
            nine_reg    <= 1'b0;
            first_reg   <= 1'b1;
            skip_reg    <= 2'd0;
            soh_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            key_reg     <= key_next;
            nine_reg    <= nine_next;
            first_reg   <= first_next;
            skip_reg    <= skip_next;
            soh_reg     <= soh_next;
        end
    end

endmodule

FILE: sv/kvpp_queue.sv
// kvpp_queue: small fifo of result runs between parser and sequencer
// register array with read and write pointers and an entry count
// depends on kvpp_pkg
`timescale 1ns / 1ps

module kvpp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kvpp_pkg::kvpp_run_t push_run,
    input  logic                pop,
    output kvpp_pkg::kvpp_run_t head_run,
    output logic                head_valid,
    output logic                full
);

    kvpp_pkg::kvpp_run_t             entry_reg [kvpp_pkg::QUEUE_DEPTH];
    logic [kvpp_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [kvpp_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head_run   = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == kvpp_pkg::QCNT_W'(kvpp_pkg::QUEUE_DEPTH));

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + kvpp_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - kvpp_pkg::QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + kvpp_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + kvpp_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

FILE: sv/kvpp_back.sv
// kvpp_back: result sequencer, sends queued results one per cycle unless stalled
// output register with valid and stall, marks the last result of a run
// depends on kvpp_pkg
`timescale 1ns / 1ps

module kvpp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  kvpp_pkg::kvpp_run_t head_run,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          result_kind,
    output logic signed [31:0]  key_number,
    output logic [7:0]          value_byte,
    output logic                last_of_run
);

    logic                          valid_reg;
    kvpp_pkg::kvpp_kind_t          kind_reg;
    logic signed [31:0]            key_reg;
    logic [7:0]                    byte_reg;
    logic                          last_reg;
    logic [kvpp_pkg::SLOT_W-1:0]   idx_reg;

    logic                          load;
    logic                          is_last;
    kvpp_pkg::kvpp_slot_t          slot;

    assign load    = !valid_reg || !out_stall;
    assign slot    = head_run.slots[idx_reg];
    assign is_last = ({1'b0, idx_reg} + kvpp_pkg::CNT_W'(1)) == head_run.count;
    assign pop     = load && head_valid && is_last;

    // slot index within the head run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                idx_reg <= is_last ? '0 : idx_reg + kvpp_pkg::SLOT_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            kind_reg <= slot.kind;
            key_reg  <= (slot.kind == kvpp_pkg::KIND_KEY) ? head_run.key : 32'sd0;
            byte_reg <= slot.value;
            last_reg <= is_last;
        end
    end

    assign out_valid   = valid_reg;
    assign result_kind = kind_reg;
    assign key_number  = key_reg;
    assign value_byte  = byte_reg;
    assign last_of_run = last_reg;

endmodule

FILE: sv/key_value_packet_parser_top.sv
// key_value_packet_parser_top: streaming key/value packet parser
// parser front, run queue and result sequencer
// depends on kvpp_pkg, kvpp_front, kvpp_queue, kvpp_back
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  input   | in_valid, in_stall, data_byte, end_of_packet         | in
//  result  | out_valid, out_stall, result_kind, key_number,       | out
//          | value_byte, last_of_run                              |
//
// a byte a cycle is parsed unless stalled; its 0 to 4 results go to a 4-deep queue
// results leave one a cycle while out_stall is low
// in_stall is high only while the run queue is full
// reset is asynchronous and returns the parser to the start of a packet
// a result waiting on out_stall holds; parsing continues until the queue fills
`timescale 1ns / 1ps

module key_value_packet_parser_top #(
    parameter int KEY_BUFFER_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_packet,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         result_kind,
    output logic signed [31:0] key_number,
    output logic [7:0]         value_byte,
    output logic               last_of_run
);

    kvpp_pkg::kvpp_run_t push_run, head_run;
    logic                push, pop, head_valid, full, accept;

    // input request accepted when valid and not stalled
    assign accept   = in_valid && !full;
    assign in_stall = full;

    kvpp_front #(
        .KEY_BUFFER_BYTES (KEY_BUFFER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .run           (push_run),
        .push          (push)
    );

    kvpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .pop        (pop),
        .head_run   (head_run),
        .head_valid (head_valid),
        .full       (full)
    );

    kvpp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_run    (head_run),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .key_number  (key_number),
        .value_byte  (value_byte),
        .last_of_run (last_of_run)
    );

endmodule
